// ----- hw/rtl/indexed_list_insert_pop_assert.svh -----
// Assertion macros for the indexed list checker
`ifndef INDEXED_LIST_INSERT_POP_ASSERT_SVH
`define INDEXED_LIST_INSERT_POP_ASSERT_SVH

// clocked check, off while reset is held
`define ILIP_ASSERT(name, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) expr) \
        else $error(msg);

// clocked check, active through reset
`define ILIP_ASSERT_RST(name, expr, msg) \
    name: assert property (@(posedge aclk) expr) \
        else $error(msg);

`endif

// ----- hw/rtl/ilip_pkg.sv -----
// Shared types and constants for the indexed list
`timescale 1ns / 1ps

package ilip_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 8;
    localparam int POS_W      = 16;
    localparam int OP_W       = 2;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int RADIX      = 4;
    localparam int STEPS      = POS_W / RADIX;
    localparam int STEP_W     = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_PEEK   = 2'd1,
        OP_POP    = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        K_INS,
        K_PEEK,
        K_POP,
        K_FULL,
        K_EMPTY,
        K_NOP
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRAP,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic                  ins_en;
        logic                  pop_en;
        logic [IDX_W-1:0]      idx;
        logic [CNT_W-1:0]      len;
        logic [DATA_WIDTH-1:0] data;
    } cell_cmd_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] idx;
    } wrap_res_t;

endpackage

// ----- hw/rtl/ilip_cell.sv -----
// One storage cell of the list: hold, load, or take a neighbor's word
`timescale 1ns / 1ps

module ilip_cell import ilip_pkg::*; (
    input  logic                  aclk,
    input  cell_cmd_t             cmd,
    input  logic [IDX_W-1:0]      cell_index,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] q
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [CNT_W-1:0]      here;
    logic [CNT_W-1:0]      at;

    assign here = CNT_W'(cell_index);
    assign at   = CNT_W'(cmd.idx);

    always_comb begin
        data_next = data_reg;
        if (cmd.ins_en) begin
            if (here == at) begin
                data_next = cmd.data;
            end else if (here > at && here <= cmd.len) begin
                data_next = left_data;
            end
        end else if (cmd.pop_en) begin
            if (here >= at && (here + CNT_W'(1)) < cmd.len) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// ----- hw/rtl/ilip_wrap.sv -----
// Signed position wrap: remainder by the modulus (the list length, or one more for an insert), RADIX bits per cycle
`timescale 1ns / 1ps

module ilip_wrap import ilip_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [POS_W-1:0] pos,
    input  logic [CNT_W-1:0]        modulus,
    output wrap_res_t               res
);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [POS_W-1:0]  mag_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W-1:0]  mod_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W-1:0]  fixed;

    always_comb begin
        rem_next = rem_reg;
        trial    = '0;
        for (int j = 0; j < RADIX; j++) begin
            trial = {rem_next, mag_reg[POS_W-1-j]};
            if (trial >= {1'b0, mod_reg}) begin
                trial = trial - {1'b0, mod_reg};
            end
            rem_next = trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            if (step_reg == STEP_W'(STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg  <= pos[POS_W-1];
            mag_reg  <= pos[POS_W-1] ? POS_W'(-pos) : POS_W'(pos);
            rem_reg  <= '0;
            mod_reg  <= modulus;
            step_reg <= '0;
        end else if (busy_reg) begin
            mag_reg  <= mag_reg << RADIX;
            rem_reg  <= rem_next;
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    assign fixed    = (neg_reg && rem_reg != '0) ? (mod_reg - rem_reg) : rem_reg;
    assign res.done = done_reg;
    assign res.idx  = fixed[IDX_W-1:0];

endmodule

// ----- hw/rtl/indexed_list_insert_pop.sv -----
// Ordered list of DEPTH words with insert, peek and pop at a wrapping signed position.
// Insert, peek and pop are accepted, then the remainder unit reduces the 16-bit position
// by the length (by the length plus one for an insert) four bits a cycle, and then the
// row of cells shifts the entries behind the position for insert and pop, and the result is
// registered. Insert into a full list, peek or pop of an empty list and the unused opcode
// skip the remainder unit. A result waits in the output register until taken; the next
// transfer is accepted meanwhile.
`timescale 1ns / 1ps

module indexed_list_insert_pop import ilip_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_operation,
    input  logic signed [POS_W-1:0] s_position,
    input  logic [DATA_WIDTH-1:0]   s_item_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [DATA_WIDTH-1:0]   m_read_value,
    output logic [1:0]              m_status,
    output logic [CNT_W-1:0]        m_count
);

    state_t                state_reg;
    state_t                state_next;
    kind_t                 kind_reg;
    kind_t                 kind_acc;
    logic [DATA_WIDTH-1:0] item_reg;
    logic [CNT_W-1:0]      len_reg;
    logic [CNT_W-1:0]      len_next;
    logic [CNT_W-1:0]      modulus;
    logic                  accept;
    logic                  out_free;
    logic                  commit;
    logic                  wrap_start;
    wrap_res_t             wres;
    cell_cmd_t             cmd;
    logic [DATA_WIDTH-1:0] cell_q [DEPTH];

    logic                  m_valid_reg;
    logic [DATA_WIDTH-1:0] m_read_value_reg;
    status_t               m_status_reg;
    logic [CNT_W-1:0]      m_count_reg;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        unique case (op_t'(s_operation))
            OP_INSERT: kind_acc = (len_reg == CNT_W'(DEPTH)) ? K_FULL : K_INS;
            OP_PEEK:   kind_acc = (len_reg == '0) ? K_EMPTY : K_PEEK;
            OP_POP:    kind_acc = (len_reg == '0) ? K_EMPTY : K_POP;
            default:   kind_acc = K_NOP;
        endcase
    end

    assign modulus    = (op_t'(s_operation) == OP_INSERT) ? len_reg + CNT_W'(1) : len_reg;
    assign wrap_start = accept && (kind_acc == K_INS || kind_acc == K_PEEK || kind_acc == K_POP);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = wrap_start ? S_WRAP : S_APPLY;
            S_WRAP:  if (wres.done) state_next = S_APPLY;
            S_APPLY: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == S_IDLE);
        commit     = (state_reg == S_APPLY) && out_free;
        cmd.ins_en = commit && (kind_reg == K_INS);
        cmd.pop_en = commit && (kind_reg == K_POP);
        cmd.idx    = wres.idx;
        cmd.len    = len_reg;
        cmd.data   = item_reg;
    end

    always_comb begin
        len_next = len_reg;
        if (cmd.ins_en) begin
            len_next = len_reg + CNT_W'(1);
        end else if (cmd.pop_en) begin
            len_next = len_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
            kind_reg    <= K_NOP;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            if (accept) begin
                kind_reg <= kind_acc;
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item_value;
        end
        if (commit) begin
            m_read_value_reg <= (kind_reg == K_PEEK || kind_reg == K_POP)
                              ? cell_q[wres.idx] : '0;
            m_count_reg      <= len_next;
            unique case (kind_reg)
                K_FULL:  m_status_reg <= STATUS_FULL;
                K_EMPTY: m_status_reg <= STATUS_EMPTY;
                default: m_status_reg <= STATUS_OK;
            endcase
        end
    end

    ilip_wrap u_wrap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (wrap_start),
        .pos     (s_position),
        .modulus (modulus),
        .res     (wres)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ilip_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .cell_index (IDX_W'(g)),
            .left_data  (cell_q[(g == 0) ? 0 : g - 1]),
            .right_data (cell_q[(g == DEPTH - 1) ? g : g + 1]),
            .q          (cell_q[g])
        );
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;
    assign m_count      = m_count_reg;

endmodule

// ----- hw/rtl/ilip_checker.sv -----
// Port-level checks for the indexed list, bound to the top level
`timescale 1ns / 1ps
`include "indexed_list_insert_pop_assert.svh"

module ilip_checker import ilip_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [DATA_WIDTH-1:0]   m_read_value,
    input logic [1:0]              m_status,
    input logic [CNT_W-1:0]        m_count
);

    `ILIP_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_read_value) && $stable(m_status) && $stable(m_count), "result changed while stalled")
    `ILIP_ASSERT(a_empty_result, m_valid && m_status == STATUS_EMPTY |-> m_count == '0 && m_read_value == '0, "empty status with data or nonzero count")
    `ILIP_ASSERT(a_full_count, m_valid && m_status == STATUS_FULL |-> m_count == CNT_W'(DEPTH), "full status without a full count")
    `ILIP_ASSERT(a_one_at_a_time, s_valid && s_ready |=> !s_ready, "input transfer accepted in consecutive cycles")
    `ILIP_ASSERT_RST(a_reset_quiet, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind indexed_list_insert_pop ilip_checker u_ilip_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_value (m_read_value),
    .m_status     (m_status),
    .m_count      (m_count)
);
